FILE: hw/rtl/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ncc_pkg;

    // Result codes of the outcome field.
    typedef enum logic [2:0] {
        OC_HIT      = 3'd0,
        OC_MISS     = 3'd1,
        OC_PLACED   = 3'd2,
        OC_REPLACED = 3'd3,
        OC_RESIDENT = 3'd4
    } outcome_t;

    // Request commands as they arrive on the request channel.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_FAULT  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_WS_LIMIT   = 1'b0;
    localparam logic CFG_MAX_SWEEPS = 1'b1;

    localparam int CFG_W = 6;
    localparam int CTR_W = 6;
    localparam logic [CTR_W-1:0] CTR_MAX = '1;
    localparam logic [CFG_W-1:0] WS_LIMIT_RESET   = 6'd32;
    localparam logic [CFG_W-1:0] MAX_SWEEPS_RESET = 6'd1;

    // Classified request kind handed from the front to the back.
    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_FAULT = 2'd2
    } kind_t;

    // Back-end sequencer states.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_DECIDE = 5'b00100,
        S_WALK   = 5'b01000,
        S_VICT   = 5'b10000
    } state_t;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } qhead_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ncc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ncc_req_if #(parameter int PAGE_BITS = 20);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [PAGE_BITS-1:0] page_number;
    logic                 is_write;
    modport source (output valid, command, page_number, is_write, input ready);
    modport sink (input valid, command, page_number, is_write, output ready);
endinterface

interface ncc_rsp_if #(parameter int PAGE_BITS = 20, parameter int SLOT_W = 5);
    logic                 valid;
    logic                 ready;
    logic [2:0]           outcome;
    logic [SLOT_W-1:0]    slot;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 victim_dirty;
    modport source (output valid, outcome, slot, victim_page, victim_dirty, input ready);
    modport sink (input valid, outcome, slot, victim_page, victim_dirty, output ready);
endinterface

interface ncc_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [5:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nchance_clock_page_replacement_top.sv
// N-chance clock page replacement over a ring of resident pages.
//
// Channels: req (sink) carries command, page_number and is_write; rsp (source)
// carries outcome, slot, victim_page and victim_dirty, one result per request;
// cfg (sink) writes ws_limit (index 0) and max_sweeps (index 1) and is always
// ready. Configuration must be changed only while no request is in flight (not enforced).
//
// A request first scans the tag memory, one slot per cycle, and a hit, miss
// or placement is then decided. A replacement adds the clock walk, one slot
// per cycle; a walk may take several laps of the ring. The scan through the
// single tag read port and the walk set the rate.
//
// A two-entry request queue keeps accepting until it is full while the back end
// works or while a result waits in the output register; a stalled rsp holds its
// result and the back end does not start the next request until it can be stored.
// Reset empties the ring, clears all used, dirty and sweep state, puts the
// hand at slot 0 and loads ws_limit 32 and max_sweeps 1.
`timescale 1ns / 1ps
`default_nettype none
module nchance_clock_page_replacement_top #(
    parameter int CAPACITY  = 32,
    parameter int PAGE_BITS = 20
) (
    input wire logic clk,
    input wire logic rst_n,
    ncc_req_if.sink  req,
    ncc_rsp_if.source rsp,
    ncc_cfg_if.sink  cfg
);
    logic [5:0]           ws_limit_reg, max_sweeps_reg;
    ncc_pkg::qhead_t      head;
    logic [PAGE_BITS-1:0] head_page;
    logic                 pop;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_limit_reg   <= ncc_pkg::WS_LIMIT_RESET;
            max_sweeps_reg <= ncc_pkg::MAX_SWEEPS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ncc_pkg::CFG_WS_LIMIT:   ws_limit_reg   <= cfg.data;
                ncc_pkg::CFG_MAX_SWEEPS: max_sweeps_reg <= cfg.data;
                default:                 ws_limit_reg   <= ws_limit_reg;
            endcase
        end
    end

    ncc_front #(.PAGE_BITS(PAGE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .head      (head),
        .head_page (head_page),
        .pop       (pop)
    );

    ncc_back #(.CAPACITY(CAPACITY), .PAGE_BITS(PAGE_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_page  (head_page),
        .pop        (pop),
        .ws_limit   (ws_limit_reg),
        .max_sweeps (max_sweeps_reg),
        .rsp        (rsp)
    );

    // Only defined outcome codes leave the block.
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.outcome == ncc_pkg::OC_HIT || rsp.outcome == ncc_pkg::OC_MISS
            || rsp.outcome == ncc_pkg::OC_PLACED || rsp.outcome == ncc_pkg::OC_REPLACED
            || rsp.outcome == ncc_pkg::OC_RESIDENT))
        else $error("undefined outcome code");

    // Victim fields are zero unless a page was replaced.
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.outcome != ncc_pkg::OC_REPLACED
            |-> rsp.victim_page == '0 && !rsp.victim_dirty)
        else $error("victim fields set without replacement");

    // A miss reports slot zero.
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.outcome == ncc_pkg::OC_MISS |-> rsp.slot == '0)
        else $error("miss with nonzero slot");
endmodule
`default_nettype wire

FILE: hw/rtl/ncc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ncc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ncc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ncc_front #(
    parameter int PAGE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ncc_req_if.sink                   req,
    output ncc_pkg::qhead_t           head,
    output logic [PAGE_BITS-1:0]      head_page,
    input  wire logic                 pop
);
    localparam int DEPTH = 2;

    ncc_pkg::kind_t       kind_reg [DEPTH];
    logic [PAGE_BITS-1:0] page_reg [DEPTH];
    logic                 wptr_reg, rptr_reg;
    logic [1:0]           count_reg;
    logic                 push;
    ncc_pkg::kind_t       kind_in;

    // Classify the request as it enters the queue.
    always_comb
    begin
        if (req.command == ncc_pkg::CMD_FAULT)
        begin
            kind_in = ncc_pkg::K_FAULT;
        end
        else if (req.is_write)
        begin
            kind_in = ncc_pkg::K_WRITE;
        end
        else
        begin
            kind_in = ncc_pkg::K_READ;
        end
    end

    assign req.ready = (count_reg != 2'(DEPTH));
    assign push      = req.valid && req.ready;

    assign head.valid = (count_reg != 2'd0);
    assign head.kind  = kind_reg[rptr_reg];
    assign head_page  = page_reg[rptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wptr_reg] <= kind_in;
            page_reg[wptr_reg] <= req.page_number;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ncc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ncc_back #(
    parameter int CAPACITY  = 32,
    parameter int PAGE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ncc_pkg::qhead_t      head,
    input  wire logic [PAGE_BITS-1:0] head_page,
    output logic                      pop,
    input  wire logic [5:0]           ws_limit,
    input  wire logic [5:0]           max_sweeps,
    ncc_rsp_if.source                 rsp
);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int LW     = FILL_W + 6;
    localparam int CW     = ncc_pkg::CTR_W;

    ncc_pkg::state_t      state_reg, state_next;
    ncc_pkg::kind_t       kind_reg, kind_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [FILL_W-1:0]    issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    pidx_reg, pidx_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hslot_reg, hslot_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]    hand_reg, hand_next;
    logic [SLOT_W-1:0]    s_reg, s_next;
    logic [CAPACITY-1:0]  used_reg, used_next;
    logic [CAPACITY-1:0]  dirty_reg, dirty_next;
    logic [CW-1:0]        ctr_reg [CAPACITY];
    logic [CW-1:0]        ctr_next [CAPACITY];

    logic                 ov_reg, ov_next;
    ncc_pkg::outcome_t    oc_reg, oc_next;
    logic [SLOT_W-1:0]    os_reg, os_next;
    logic [PAGE_BITS-1:0] ovp_reg, ovp_next;
    logic                 ovd_reg, ovd_next;

    logic                 ram_we, ram_re;
    logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
    logic [PAGE_BITS-1:0] ram_rdata;

    logic [LW-1:0]        limit;
    logic                 neg;
    logic [CW-1:0]        mag, thr, ctr_inc;
    logic [SLOT_W-1:0]    s_wrap;

    // Tag store.
    ncc_ram #(.WIDTH(PAGE_BITS), .DEPTH(CAPACITY)) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (page_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective ring limit, sweep threshold, saturating counter step and wrapped slot.
    always_comb
    begin
        if (ws_limit == 6'd0)
        begin
            limit = LW'(1);
        end
        else if (LW'(ws_limit) > LW'(CAPACITY))
        begin
            limit = LW'(CAPACITY);
        end
        else
        begin
            limit = LW'(ws_limit);
        end
        neg     = max_sweeps[5];
        mag     = neg ? CW'(-max_sweeps) : max_sweeps;
        thr     = mag + CW'(neg && dirty_reg[s_reg]);
        ctr_inc = (ctr_reg[s_reg] == ncc_pkg::CTR_MAX) ? ctr_reg[s_reg]
                                                       : ctr_reg[s_reg] + CW'(1);
        s_wrap  = (FILL_W'(s_reg) + FILL_W'(1) >= fill_reg) ? '0 : s_reg + SLOT_W'(1);
    end

    assign rsp.valid        = ov_reg;
    assign rsp.outcome      = oc_reg;
    assign rsp.slot         = os_reg;
    assign rsp.victim_page  = ovp_reg;
    assign rsp.victim_dirty = ovd_reg;

    // Sequencer: search, decide, walk, evict.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        page_next  = page_reg;
        issue_next = issue_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        hit_next   = hit_reg;
        hslot_next = hslot_reg;
        fill_next  = fill_reg;
        hand_next  = hand_reg;
        s_next     = s_reg;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        ctr_next   = ctr_reg;
        ov_next    = ov_reg && !rsp.ready;
        oc_next    = oc_reg;
        os_next    = os_reg;
        ovp_next   = ovp_reg;
        ovd_next   = ovd_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = s_reg;
        ram_re     = 1'b0;
        ram_raddr  = issue_reg[SLOT_W-1:0];

        case (state_reg)
            ncc_pkg::S_IDLE:
            begin
                // Start only when the result register will be free.
                if (head.valid && (!ov_reg || rsp.ready))
                begin
                    pop        = 1'b1;
                    kind_next  = head.kind;
                    page_next  = head_page;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ncc_pkg::S_SEARCH;
                end
            end
            ncc_pkg::S_SEARCH:
            begin
                // At most one tag read issued and one compared each cycle.
                if (pend_reg && ram_rdata == page_reg)
                begin
                    hit_next   = 1'b1;
                    hslot_next = pidx_reg;
                    state_next = ncc_pkg::S_DECIDE;
                end
                else if (issue_reg < fill_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[SLOT_W-1:0];
                    issue_next = issue_reg + FILL_W'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = ncc_pkg::S_DECIDE;
                end
            end
            ncc_pkg::S_DECIDE:
            begin
                state_next = ncc_pkg::S_IDLE;
                ovp_next   = '0;
                ovd_next   = 1'b0;
                os_next    = '0;
                if (kind_reg != ncc_pkg::K_FAULT)
                begin
                    ov_next = 1'b1;
                    if (hit_reg)
                    begin
                        oc_next              = ncc_pkg::OC_HIT;
                        os_next              = hslot_reg;
                        used_next[hslot_reg] = 1'b1;
                        if (kind_reg == ncc_pkg::K_WRITE)
                        begin
                            dirty_next[hslot_reg] = 1'b1;
                        end
                    end
                    else
                    begin
                        oc_next = ncc_pkg::OC_MISS;
                    end
                end
                else if (hit_reg)
                begin
                    ov_next = 1'b1;
                    oc_next = ncc_pkg::OC_RESIDENT;
                    os_next = hslot_reg;
                end
                else if (LW'(fill_reg) < limit)
                begin
                    // Append to the ring.
                    ov_next    = 1'b1;
                    oc_next    = ncc_pkg::OC_PLACED;
                    os_next    = fill_reg[SLOT_W-1:0];
                    ram_we     = 1'b1;
                    ram_waddr  = fill_reg[SLOT_W-1:0];
                    used_next[fill_reg[SLOT_W-1:0]]  = 1'b0;
                    dirty_next[fill_reg[SLOT_W-1:0]] = 1'b0;
                    ctr_next[fill_reg[SLOT_W-1:0]]   = '0;
                    fill_next  = fill_reg + FILL_W'(1);
                    if (LW'(fill_reg) + LW'(1) >= limit)
                    begin
                        hand_next = '0;
                    end
                end
                else
                begin
                    s_next     = (FILL_W'(hand_reg) >= fill_reg) ? '0 : hand_reg;
                    state_next = ncc_pkg::S_WALK;
                end
            end
            ncc_pkg::S_WALK:
            begin
                // One slot visited per cycle.
                if (used_reg[s_reg])
                begin
                    used_next[s_reg] = 1'b0;
                    ctr_next[s_reg]  = '0;
                    s_next           = s_wrap;
                end
                else
                begin
                    ctr_next[s_reg] = ctr_inc;
                    if (ctr_inc >= thr)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = s_reg;
                        state_next = ncc_pkg::S_VICT;
                    end
                    else
                    begin
                        s_next = s_wrap;
                    end
                end
            end
            ncc_pkg::S_VICT:
            begin
                // Victim tag is on the read port; install the new page.
                ram_we           = 1'b1;
                ov_next          = 1'b1;
                oc_next          = ncc_pkg::OC_REPLACED;
                os_next          = s_reg;
                ovp_next         = ram_rdata;
                ovd_next         = dirty_reg[s_reg];
                used_next[s_reg]  = 1'b0;
                dirty_next[s_reg] = 1'b0;
                ctr_next[s_reg]   = '0;
                hand_next        = s_wrap;
                state_next       = ncc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ncc_pkg::S_IDLE;
            end
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        page_reg  <= page_next;
        pidx_reg  <= pidx_next;
        hslot_reg <= hslot_next;
        s_reg     <= s_next;
        oc_reg    <= oc_next;
        os_reg    <= os_next;
        ovp_reg   <= ovp_next;
        ovd_reg   <= ovd_next;
    end

    // Control and per-slot state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncc_pkg::S_IDLE;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            fill_reg  <= '0;
            hand_reg  <= '0;
            used_reg  <= '0;
            dirty_reg <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                ctr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            fill_reg  <= fill_next;
            hand_reg  <= hand_next;
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
            ov_reg    <= ov_next;
            ctr_reg   <= ctr_next;
        end
    end
endmodule
`default_nettype wire
